/* design/csmatx_pkg.sv */
// Shared types, codes and constants of the CSMA-CA transmit controller.
package csmatx_pkg;

  localparam int TIMER_BITS = 24;
  localparam int PROD_W     = 24;
  localparam int SAT_W      = (TIMER_BITS > PROD_W) ? TIMER_BITS : PROD_W;

  localparam logic [2:0] EV_SEND   = 3'd0;
  localparam logic [2:0] EV_TICK   = 3'd1;
  localparam logic [2:0] EV_CCA    = 3'd2;
  localparam logic [2:0] EV_TXDONE = 3'd3;
  localparam logic [2:0] EV_ACK    = 3'd4;

  localparam logic [2:0] REG_CSMA_EN   = 3'd0;
  localparam logic [2:0] REG_ACK_EN    = 3'd1;
  localparam logic [2:0] REG_MIN_BE    = 3'd2;
  localparam logic [2:0] REG_MAX_BE    = 3'd3;
  localparam logic [2:0] REG_MAX_TRIAL = 3'd4;
  localparam logic [2:0] REG_UNIT      = 3'd5;
  localparam logic [2:0] REG_MAX_RETX  = 3'd6;
  localparam logic [2:0] REG_ACK_TMO   = 3'd7;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_CCA  = 2'd1,
    CMD_TX   = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_BACKOFF = 5'b00010,
    PH_CCA     = 5'b00100,
    PH_TXDONE  = 5'b01000,
    PH_ACK     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        csma_en;
    logic        ack_en;
    logic [3:0]  min_be;
    logic [3:0]  max_be;
    logic [3:0]  max_trials;
    logic [15:0] unit;
    logic [2:0]  max_retx;
    logic [15:0] ack_tmo;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [3:0]            be;
    logic [3:0]            trials;
    logic [2:0]            retry;
    logic [TIMER_BITS-1:0] countdown;
    logic                  ack_mode;
  } state_t;

  typedef struct packed {
    cmd_t       command;
    logic       busy;
    logic       done;
    logic       success;
    logic [2:0] retries;
  } res_t;

endpackage

/* design/csmatx_step.sv */
// Next-state and result logic for one event word of the CSMA-CA controller.
module csmatx_step
  import csmatx_pkg::*;
(
  input  state_t     st,
  input  cfg_t       cfg,
  input  logic [2:0] func,
  input  logic       need_ack,
  input  logic       channel_clear,
  input  logic [7:0] random_value,
  output state_t     st_nxt,
  output res_t       res
);

  logic             fail;
  logic             start;
  logic             do_draw;
  logic             fin;
  logic             fin_ok;
  cmd_t             cmd;
  logic [3:0]       trial_inc;
  logic [7:0]       mask;
  logic [7:0]       rnd_m;
  logic [PROD_W-1:0] prod;
  logic [SAT_W-1:0] dly;
  logic [SAT_W-1:0] tmax;

  always_comb begin
    st_nxt    = st;
    fail      = 1'b0;
    start     = 1'b0;
    do_draw   = 1'b0;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    cmd       = CMD_NONE;
    trial_inc = st.trials + 4'd1;

    case (func)
      EV_SEND: begin
        if (st.phase == PH_IDLE) begin
          st_nxt.ack_mode = need_ack & cfg.ack_en;
          st_nxt.retry    = 3'd0;
          start           = 1'b1;
        end
      end
      EV_TICK: begin
        if (st.phase == PH_BACKOFF || st.phase == PH_ACK) begin
          if (st.countdown <= TIMER_BITS'(1)) begin
            st_nxt.countdown = '0;
            if (st.phase == PH_BACKOFF) begin
              cmd          = CMD_CCA;
              st_nxt.phase = PH_CCA;
            end else begin
              fail = 1'b1;
            end
          end else begin
            st_nxt.countdown = st.countdown - TIMER_BITS'(1);
          end
        end
      end
      EV_CCA: begin
        if (st.phase == PH_CCA) begin
          if (channel_clear) begin
            st_nxt.phase = PH_TXDONE;
          end else begin
            st_nxt.trials = trial_inc;
            if (trial_inc >= cfg.max_trials) begin
              fail = 1'b1;
            end else begin
              if (st.be < cfg.max_be) begin
                st_nxt.be = st.be + 4'd1;
              end
              do_draw = 1'b1;
            end
          end
        end
      end
      EV_TXDONE: begin
        if (st.phase == PH_TXDONE) begin
          if (st.ack_mode) begin
            st_nxt.countdown = TIMER_BITS'(cfg.ack_tmo);
            st_nxt.phase     = PH_ACK;
          end else begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end
        end
      end
      EV_ACK: begin
        if (st.phase == PH_ACK) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // failed attempt: retry or give up
    if (fail) begin
      if (st_nxt.ack_mode && st_nxt.retry < cfg.max_retx) begin
        st_nxt.retry = st_nxt.retry + 3'd1;
        start        = 1'b1;
      end else begin
        fin = 1'b1;
      end
    end

    if (start) begin
      if (cfg.csma_en) begin
        st_nxt.be     = cfg.min_be;
        st_nxt.trials = 4'd0;
        if (cfg.max_trials == 4'd0) begin
          // every retry fails at once: jump to the retry limit
          if (st_nxt.ack_mode && st_nxt.retry < cfg.max_retx) begin
            st_nxt.retry = cfg.max_retx;
          end
          fin = 1'b1;
        end else begin
          do_draw = 1'b1;
        end
      end else begin
        cmd          = CMD_TX;
        st_nxt.phase = PH_TXDONE;
      end
    end

    // backoff draw: max(unit, (rnd mod 2^BE) * unit), saturated
    mask  = (st_nxt.be >= 4'd8) ? 8'hFF : ((8'd1 << st_nxt.be[2:0]) - 8'd1);
    rnd_m = random_value & mask;
    prod  = PROD_W'(rnd_m) * PROD_W'(cfg.unit);
    dly   = (rnd_m == 8'd0) ? SAT_W'(cfg.unit) : SAT_W'(prod);
    tmax  = SAT_W'({TIMER_BITS{1'b1}});
    if (dly > tmax) begin
      dly = tmax;
    end
    if (do_draw) begin
      st_nxt.countdown = dly[TIMER_BITS-1:0];
      st_nxt.phase     = PH_BACKOFF;
    end

    if (fin) begin
      st_nxt.phase     = PH_IDLE;
      st_nxt.countdown = '0;
    end

    res.command = cmd;
    res.busy    = (st_nxt.phase != PH_IDLE);
    res.done    = fin;
    res.success = fin & fin_ok;
    res.retries = st_nxt.retry;
  end

endmodule

/* design/csma_ca_transmit_controller.sv */
// Top level of the unslotted CSMA-CA transmit controller with acknowledgement retries.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event word: in_func selects send
//   request, timer tick, clear-channel result, transmit done or ack received; the
//   other fields qualify it. Every event word yields exactly one result word on the
//   output channel (out_valid/out_ready): radio command, busy, done, success and
//   the retransmission count of the current frame.
//   Configuration registers are written through cfg_wr_en/cfg_index/cfg_data with
//   no wait; the user must write them only while no event word is in flight, as the block itself does not enforce it.
//   An accepted event word passes from the input register through the next-state logic
//   into the state and result registers. Throughput: one event word per cycle while
//   out_ready does not stall; the next-state logic holds a single 8x16 multiplier for
//   the backoff draw and updates the state and the result register together.
//   Reset (rst_n low, synchronous) empties both registers, returns to idle with all
//   counters zero and loads the register defaults.
//   A stall on out_ready holds the result word; the input register still takes one
//   more word, after which in_ready drops until the result word leaves.
module csma_ca_transmit_controller
  import csmatx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic        in_need_ack,
  input  logic        in_channel_clear,
  input  logic [7:0]  in_random_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_command,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_success,
  output logic [2:0]  out_retries_used,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg_r;
  state_t     st_r;
  state_t     st_nxt;
  res_t       res_nxt;
  res_t       res_r;
  logic       in_v_r;
  logic       out_v_r;
  logic [2:0] func_r;
  logic       need_ack_r;
  logic       clear_r;
  logic [7:0] rnd_r;
  logic       adv;
  logic       fire;

  assign adv      = !out_v_r || out_ready;
  assign fire     = in_v_r && adv;
  assign in_ready = !in_v_r || adv;

  csmatx_step u_step (
    .st            (st_r),
    .cfg           (cfg_r),
    .func          (func_r),
    .need_ack      (need_ack_r),
    .channel_clear (clear_r),
    .random_value  (rnd_r),
    .st_nxt        (st_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.csma_en    <= 1'b1;
      cfg_r.ack_en     <= 1'b1;
      cfg_r.min_be     <= 4'd3;
      cfg_r.max_be     <= 4'd5;
      cfg_r.max_trials <= 4'd5;
      cfg_r.unit       <= 16'd320;
      cfg_r.max_retx   <= 3'd3;
      cfg_r.ack_tmo    <= 16'd864;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CSMA_EN:   cfg_r.csma_en    <= cfg_data[0];
        REG_ACK_EN:    cfg_r.ack_en     <= cfg_data[0];
        REG_MIN_BE:    cfg_r.min_be     <= cfg_data[3:0];
        REG_MAX_BE:    cfg_r.max_be     <= cfg_data[3:0];
        REG_MAX_TRIAL: cfg_r.max_trials <= cfg_data[3:0];
        REG_UNIT:      cfg_r.unit       <= cfg_data;
        REG_MAX_RETX:  cfg_r.max_retx   <= cfg_data[2:0];
        REG_ACK_TMO:   cfg_r.ack_tmo    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      st_r.phase  <= PH_IDLE;
      st_r.be     <= '0;
      st_r.trials <= '0;
      st_r.retry  <= '0;
      st_r.countdown <= '0;
      st_r.ack_mode  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (fire) begin
        st_r    <= st_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r     <= in_func;
      need_ack_r <= in_need_ack;
      clear_r    <= in_channel_clear;
      rnd_r      <= in_random_value;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_command      = res_r.command;
  assign out_busy_res     = res_r.busy;
  assign out_done_res     = res_r.done;
  assign out_success      = res_r.success;
  assign out_retries_used = res_r.retries;

endmodule

/* design/csmatx_checker.sv */
// Port-level checks of the CSMA-CA transmit controller, bound to the top level.
module csmatx_checker
  import csmatx_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_command,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic       out_success,
  input logic [2:0] out_retries_used
);

  a_succ_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_success |-> out_done_res)
    else $error("success without done");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done while still busy");

  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command != CMD_NONE |-> out_busy_res && !out_done_res)
    else $error("radio command outside a transmission");

  a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_command == CMD_NONE || out_command == CMD_CCA ||
                  out_command == CMD_TX)
    else $error("illegal command code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command) &&
      $stable(out_busy_res) && $stable(out_done_res) && $stable(out_success) &&
      $stable(out_retries_used))
    else $error("stalled result word changed");

endmodule

bind csma_ca_transmit_controller csmatx_checker u_csmatx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_command      (out_command),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res),
  .out_success      (out_success),
  .out_retries_used (out_retries_used)
);

/* tb/csma_ca_transmit_controller_tb.sv */
// Self-checking testbench for the CSMA-CA transmit controller: directed table, random events.
`timescale 1ns / 1ps

module csma_ca_transmit_controller_tb;
  import csmatx_pkg::*;

  localparam int PACE_FREE = 0;
  localparam int PACE_SRC  = 1;
  localparam int PACE_SINK = 2;
  localparam int PACE_BOTH = 3;

  typedef struct {
    bit         is_regs;
    cfg_t       regs;
    logic [2:0] func;
    logic       need;
    logic       clear;
    logic [7:0] rnd;
    bit         sure;
    res_t       want;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic        in_need_ack;
  logic        in_channel_clear;
  logic [7:0]  in_random_value;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  out_command;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_success;
  logic [2:0]  out_retries_used;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  csma_ca_transmit_controller dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int pace = PACE_FREE;

  always @(posedge clk) begin
    if (pace == PACE_SINK) begin
      out_ready <= $urandom_range(0, 99) >= 85;
    end else if (pace == PACE_BOTH) begin
      out_ready <= $urandom_range(0, 99) >= 18;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predictor state and register image
  cfg_t                  regs;
  phase_t                p_phase;
  logic [3:0]            p_be;
  logic [3:0]            p_trials;
  logic [2:0]            p_retry;
  logic [TIMER_BITS-1:0] p_count;
  logic                  p_ack;
  cmd_t                  o_cmd;
  logic                  o_done;
  logic                  o_ok;

  res_t status_due[$];
  int   status_misses = 0;

  function automatic void load_count(longint unsigned v);
    longint unsigned cap = (64'd1 << TIMER_BITS) - 1;
    p_count = TIMER_BITS'((v > cap) ? cap : v);
  endfunction

  function automatic void draw_backoff(logic [7:0] rv);
    longint unsigned span;
    longint unsigned delay;
    span  = (64'd1 << p_be) - 1;
    delay = (rv & span) * regs.unit;
    if (delay < regs.unit) delay = regs.unit;
    load_count(delay);
    p_phase = PH_BACKOFF;
  endfunction

  function automatic void close_frame(logic ok);
    p_phase = PH_IDLE;
    p_count = '0;
    o_done  = 1'b1;
    o_ok    = ok;
  endfunction

  // Returns 1 when the attempt fails before any backoff.
  function automatic bit begin_attempt(logic [7:0] rv);
    if (regs.csma_en) begin
      p_be     = regs.min_be;
      p_trials = '0;
      if (regs.max_trials == 0) return 1'b1;
      draw_backoff(rv);
    end else begin
      o_cmd   = CMD_TX;
      p_phase = PH_TXDONE;
    end
    return 1'b0;
  endfunction

  function automatic void give_up(logic [7:0] rv);
    while (1) begin
      if (p_ack && p_retry < regs.max_retx) begin
        p_retry = p_retry + 3'd1;
        if (!begin_attempt(rv)) return;
      end else begin
        close_frame(1'b0);
        return;
      end
    end
  endfunction

  function automatic res_t next_tx_status(logic [2:0] f, logic na, logic cc, logic [7:0] rv);
    res_t r;
    o_cmd  = CMD_NONE;
    o_done = 1'b0;
    o_ok   = 1'b0;
    case (f)
      EV_SEND: if (p_phase == PH_IDLE) begin
        p_ack   = na & regs.ack_en;
        p_retry = '0;
        if (begin_attempt(rv)) give_up(rv);
      end
      EV_TICK: if (p_phase == PH_BACKOFF || p_phase == PH_ACK) begin
        if (p_count <= 1) begin
          p_count = '0;
          if (p_phase == PH_BACKOFF) begin
            o_cmd   = CMD_CCA;
            p_phase = PH_CCA;
          end else begin
            give_up(rv);
          end
        end else begin
          p_count = p_count - 1'b1;
        end
      end
      EV_CCA: if (p_phase == PH_CCA) begin
        if (cc) begin
          p_phase = PH_TXDONE;
        end else begin
          p_trials = p_trials + 4'd1;
          if (p_trials >= regs.max_trials) begin
            give_up(rv);
          end else begin
            if (p_be < regs.max_be) p_be = p_be + 4'd1;
            draw_backoff(rv);
          end
        end
      end
      EV_TXDONE: if (p_phase == PH_TXDONE) begin
        if (p_ack) begin
          load_count(regs.ack_tmo);
          p_phase = PH_ACK;
        end else begin
          close_frame(1'b1);
        end
      end
      EV_ACK: if (p_phase == PH_ACK) begin
        close_frame(1'b1);
      end
      default: ;
    endcase
    r.command = o_cmd;
    r.busy    = p_phase != PH_IDLE;
    r.done    = o_done;
    r.success = o_ok;
    r.retries = p_retry;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        status_misses++;
        if (status_misses <= 10)
          $display("%0t: unexpected result word cmd=%0d busy=%0b done=%0b ok=%0b retries=%0d",
                   $time, out_command, out_busy_res, out_done_res, out_success,
                   out_retries_used);
      end else begin
        want = status_due.pop_front();
        if (out_command !== want.command || out_busy_res !== want.busy ||
            out_done_res !== want.done || out_success !== want.success ||
            out_retries_used !== want.retries) begin
          status_misses++;
          if (status_misses <= 10) begin
            $write("%0t: mismatch expected cmd=%0d busy=%0b done=%0b ok=%0b retries=%0d,",
                   $time, want.command, want.busy, want.done, want.success, want.retries);
            $display(" got cmd=%0d busy=%0b done=%0b ok=%0b retries=%0d",
                     out_command, out_busy_res, out_done_res, out_success, out_retries_used);
          end
        end
      end
    end
  end

  task automatic push_word(input logic [2:0] f, input logic na, input logic cc,
                           input logic [7:0] rv, input bit sure, input res_t want);
    res_t guess;
    int   pct;
    in_valid         <= 1'b1;
    in_func          <= f;
    in_need_ack      <= na;
    in_channel_clear <= cc;
    in_random_value  <= rv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = next_tx_status(f, na, cc, rv);
    status_due.push_back(sure ? want : guess);
    pct = (pace == PACE_SRC) ? 85 : (pace == PACE_BOTH) ? 18 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic quiesce();
    if (in_valid) in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // Drive the frame in progress to completion; optionally let the ack timer run out.
  task automatic settle(input bit let_expire);
    int         keep;
    logic [2:0] f;
    keep = pace;
    pace = PACE_FREE;
    while (p_phase != PH_IDLE) begin
      case (p_phase)
        PH_CCA:    f = EV_CCA;
        PH_TXDONE: f = EV_TXDONE;
        PH_ACK:    f = let_expire ? EV_TICK : EV_ACK;
        default:   f = EV_TICK;
      endcase
      push_word(f, 1'b0, 1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
    pace = keep;
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic reprogram(input cfg_t r);
    settle(1'b0);
    quiesce();
    put_reg(REG_CSMA_EN, 16'(r.csma_en));
    put_reg(REG_ACK_EN, 16'(r.ack_en));
    put_reg(REG_MIN_BE, 16'(r.min_be));
    put_reg(REG_MAX_BE, 16'(r.max_be));
    put_reg(REG_MAX_TRIAL, 16'(r.max_trials));
    put_reg(REG_UNIT, r.unit);
    put_reg(REG_MAX_RETX, 16'(r.max_retx));
    put_reg(REG_ACK_TMO, r.ack_tmo);
    cfg_wr_en <= 1'b0;
    regs = r;
  endtask

  function automatic probe_t step_row(logic [2:0] f, logic na, logic cc, logic [7:0] rv);
    probe_t p;
    p.is_regs = 1'b0;
    p.regs    = '0;
    p.func    = f;
    p.need    = na;
    p.clear   = cc;
    p.rnd     = rv;
    p.sure    = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  function automatic probe_t known_row(logic [2:0] f, logic na, logic cc, logic [7:0] rv,
                                       cmd_t c, logic b, logic d, logic ok, logic [2:0] rt);
    probe_t p;
    p = step_row(f, na, cc, rv);
    p.sure         = 1'b1;
    p.want.command = c;
    p.want.busy    = b;
    p.want.done    = d;
    p.want.success = ok;
    p.want.retries = rt;
    return p;
  endfunction

  function automatic probe_t regs_row(cfg_t r);
    probe_t p;
    p = step_row(EV_TICK, 1'b0, 1'b0, 8'd0);
    p.is_regs = 1'b1;
    p.regs    = r;
    return p;
  endfunction

  localparam cfg_t TINY = '{csma_en: 1'b1, ack_en: 1'b1, min_be: 4'd3, max_be: 4'd1,
                            max_trials: 4'd2, unit: 16'd0, max_retx: 3'd1, ack_tmo: 16'd0};

  probe_t script[$];

  initial begin
    cfg_t       no_csma;
    cfg_t       no_trials;
    cfg_t       pick;
    cfg_t       heavy;
    logic [2:0] f;
    int         well;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = EV_TICK;
    in_need_ack      = 1'b0;
    in_channel_clear = 1'b0;
    in_random_value  = 8'd0;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_CSMA_EN;
    cfg_data         = 16'd0;

    regs = '{csma_en: 1'b1, ack_en: 1'b1, min_be: 4'd3, max_be: 4'd5, max_trials: 4'd5,
             unit: 16'd320, max_retx: 3'd3, ack_tmo: 16'd864};
    p_phase  = PH_IDLE;
    p_be     = '0;
    p_trials = '0;
    p_retry  = '0;
    p_count  = '0;
    p_ack    = 1'b0;

    no_csma           = TINY;
    no_csma.csma_en   = 1'b0;
    no_trials         = TINY;
    no_trials.max_trials = 4'd0;

    script = '{
      known_row(EV_TICK, 1'b0, 1'b0, 8'd0, CMD_NONE, 1'b0, 1'b0, 1'b0, 3'd0),
      known_row(3'd7, 1'b1, 1'b1, 8'hff, CMD_NONE, 1'b0, 1'b0, 1'b0, 3'd0),
      known_row(EV_CCA, 1'b1, 1'b1, 8'hff, CMD_NONE, 1'b0, 1'b0, 1'b0, 3'd0),
      known_row(EV_SEND, 1'b1, 1'b0, 8'd0, CMD_NONE, 1'b1, 1'b0, 1'b0, 3'd0),
      known_row(EV_SEND, 1'b1, 1'b0, 8'hff, CMD_NONE, 1'b1, 1'b0, 1'b0, 3'd0),
      regs_row(TINY),
      step_row(EV_SEND, 1'b1, 1'b0, 8'hff),
      known_row(EV_TICK, 1'b0, 1'b0, 8'd0, CMD_CCA, 1'b1, 1'b0, 1'b0, 3'd0),
      step_row(EV_CCA, 1'b0, 1'b0, 8'hff),
      step_row(EV_TICK, 1'b0, 1'b0, 8'h55),
      step_row(EV_CCA, 1'b0, 1'b0, 8'd0),
      step_row(EV_TICK, 1'b0, 1'b0, 8'haa),
      step_row(EV_CCA, 1'b0, 1'b1, 8'd0),
      step_row(EV_ACK, 1'b0, 1'b0, 8'd0),
      step_row(EV_TXDONE, 1'b0, 1'b0, 8'd0),
      known_row(EV_TICK, 1'b0, 1'b0, 8'd0, CMD_NONE, 1'b0, 1'b1, 1'b0, 3'd1),
      known_row(EV_ACK, 1'b0, 1'b0, 8'd0, CMD_NONE, 1'b0, 1'b0, 1'b0, 3'd1),
      step_row(EV_SEND, 1'b0, 1'b0, 8'd1),
      step_row(EV_TICK, 1'b0, 1'b0, 8'd0),
      step_row(EV_CCA, 1'b0, 1'b1, 8'd0),
      known_row(EV_TXDONE, 1'b0, 1'b0, 8'd0, CMD_NONE, 1'b0, 1'b1, 1'b1, 3'd0),
      regs_row(no_csma),
      known_row(EV_SEND, 1'b1, 1'b0, 8'd0, CMD_TX, 1'b1, 1'b0, 1'b0, 3'd0),
      step_row(EV_TXDONE, 1'b0, 1'b0, 8'd0),
      known_row(EV_ACK, 1'b0, 1'b0, 8'd0, CMD_NONE, 1'b0, 1'b1, 1'b1, 3'd0),
      regs_row(no_trials),
      known_row(EV_SEND, 1'b1, 1'b0, 8'd0, CMD_NONE, 1'b0, 1'b1, 1'b0, 3'd1),
      known_row(3'd5, 1'b1, 1'b1, 8'hff, CMD_NONE, 1'b0, 1'b0, 1'b0, 3'd1)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_regs) begin
        reprogram(script[i].regs);
      end else begin
        push_word(script[i].func, script[i].need, script[i].clear, script[i].rnd,
                  script[i].sure, script[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      pick.csma_en    = $urandom_range(0, 4) != 0;
      pick.ack_en     = $urandom_range(0, 3) != 0;
      pick.min_be     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 8)) :
                                                      4'($urandom_range(0, 2));
      pick.max_be     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 8)) :
                                                      4'($urandom_range(0, 3));
      pick.max_trials = 4'($urandom_range(1, 15));
      pick.unit       = 16'($urandom_range(1, 2));
      pick.max_retx   = 3'($urandom_range(0, 7));
      pick.ack_tmo    = 16'($urandom_range(1, 24));
      if (ph == 0) begin
        pick = '{csma_en: 1'b0, ack_en: 1'b0, min_be: 4'd0, max_be: 4'd0, max_trials: 4'd1,
                 unit: 16'd1, max_retx: 3'd0, ack_tmo: 16'd1};
      end else if (ph == 7) begin
        pick = '{csma_en: 1'b1, ack_en: 1'b1, min_be: 4'd8, max_be: 4'd8, max_trials: 4'd15,
                 unit: 16'd1, max_retx: 3'd7, ack_tmo: 16'd24};
      end
      reprogram(pick);
      pace = ph % 4;
      well = 0;
      while (well < 150) begin
        if ($urandom_range(0, 199) == 0) quiesce();
        if ($urandom_range(0, 99) < 80) begin
          case (p_phase)
            PH_IDLE:    f = EV_SEND;
            PH_BACKOFF: f = EV_TICK;
            PH_CCA:     f = EV_CCA;
            PH_TXDONE:  f = EV_TXDONE;
            default:    f = ($urandom_range(0, 3) == 0) ? EV_ACK : EV_TICK;
          endcase
          well++;
        end else begin
          f = 3'($urandom_range(0, 7));
        end
        push_word(f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'b0, '0);
      end
      pace = PACE_FREE;
    end

    // Long delay and ack timeout: one frame, run both timers out.
    heavy = '{csma_en: 1'b1, ack_en: 1'b1, min_be: 4'd0, max_be: 4'd8, max_trials: 4'd15,
              unit: 16'd200, max_retx: 3'd0, ack_tmo: 16'd200};
    reprogram(heavy);
    push_word(EV_SEND, 1'b1, 1'b0, 8'hff, 1'b0, '0);
    settle(1'b1);

    quiesce();
    repeat (8) @(posedge clk);
    if (status_misses == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
design/csmatx_pkg.sv
design/csmatx_step.sv
design/csma_ca_transmit_controller.sv
design/csmatx_checker.sv
tb/csma_ca_transmit_controller_tb.sv
